[hdl/msa_residue_pair_scorer_top_defines.svh]
// ----------------------------------------------------------------------------
// msa_residue_pair_scorer_top_defines
// assertion macros for the checker file of the pair scorer
// ----------------------------------------------------------------------------
`ifndef MSA_RESIDUE_PAIR_SCORER_TOP_DEFINES_SVH
`define MSA_RESIDUE_PAIR_SCORER_TOP_DEFINES_SVH

// clocked assertion, switched off while reset is low
`define MRPS_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("msa residue pair scorer: assertion failed");

// clocked assertion that also holds during reset
`define MRPS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("msa residue pair scorer: assertion failed");

`endif

[hdl/mrps_pkg.sv]
// ----------------------------------------------------------------------------
// mrps_pkg
// constants, codes and controller/datapath types of the residue pair scorer
// ----------------------------------------------------------------------------
package mrps_pkg;

    // alignment size; the column count must stay a power of two
    localparam int NUM_SEQS = 8;
    localparam int NUM_COLS = 1024;

    localparam int ROW_W  = $clog2(NUM_SEQS);
    localparam int FCNT_W = $clog2(NUM_SEQS + 1);
    localparam int COL_W  = $clog2(NUM_COLS);
    localparam int DEPTH  = NUM_SEQS * NUM_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    // code and count widths
    localparam int CNT_W  = 11;
    localparam int CODE_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // field widths
    localparam int CMD_W       = 2;
    localparam int SEQ_ROW_W   = 3;
    localparam int COLUMN_W    = 10;
    localparam int OUTCOME_W   = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_REF = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_ALT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCORE    = 2'd2;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_GAP  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_MISS = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_HIT  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic             load_ref;
        logic             load_alt;
        logic             cap_col;
        logic             fetch_re;
        logic [ROW_W-1:0] fetch_row;
        logic             store_en;
        logic [ROW_W-1:0] store_row;
        logic             row_start;
        logic [ROW_W-1:0] rsel;
        logic [ROW_W-1:0] row1;
        logic [ROW_W-1:0] row2;
        logic             alt_re;
        logic             alt_from_ram;
        logic             emit;
        logic             last;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

[hdl/msa_residue_pair_scorer_top.sv]
// Residue pair scorer for two alignments of 8 rows by 1024 columns. Load items
// (accepted back to back) write one cell of the reference or alternative
// alignment; a score item reads the 8 reference codes of the column through
// the single read port of the reference code memory, then per first row does
// the residue column lookup and then the alternative code prefetch, and emits
// one row pair per cycle while the output is ready: 28 results per item, after
// which the next item is accepted. The last result may still wait in the
// output register while the next item is taken.
// ----------------------------------------------------------------------------
// msa_residue_pair_scorer_top
// compares reference and alternative alignments pair by pair per column
// ----------------------------------------------------------------------------
module msa_residue_pair_scorer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // cmd[1:0], seq_row[4:2], column[14:5], is_residue[15]
    input  logic [mrps_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // first_row[2:0], second_row[5:3], outcome[7:6]
    output logic [mrps_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // last_pair
    output logic                             o_m_tlast
);

    import mrps_pkg::*;

    t_dp_cmd              dp_cmd;
    t_dp_sts              dp_sts;
    logic [CMD_W-1:0]     in_cmd;
    logic [SEQ_ROW_W-1:0] in_seq_row;
    logic [COLUMN_W-1:0]  in_column;
    logic                 in_is_residue;
    logic [2:0]           out_first_row;
    logic [2:0]           out_second_row;
    logic [OUTCOME_W-1:0] out_outcome;

    // input field unpacking
    assign in_cmd        = i_s_tdata[1:0];
    assign in_seq_row    = i_s_tdata[4:2];
    assign in_column     = i_s_tdata[14:5];
    assign in_is_residue = i_s_tdata[15];

    mrps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_cmd_code (in_cmd),
        .i_seq_row  (in_seq_row),
        .i_column   (in_column),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    mrps_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_seq_row    (in_seq_row),
        .i_column     (in_column),
        .i_is_residue (in_is_residue),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_first_row  (out_first_row),
        .o_second_row (out_second_row),
        .o_outcome    (out_outcome),
        .o_last_pair  (o_m_tlast)
    );

    // output field packing
    assign o_m_tdata = {out_outcome, out_second_row, out_first_row};

endmodule

[hdl/mrps_ram.sv]
// ----------------------------------------------------------------------------
// mrps_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mrps_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/mrps_dp.sv]
// ----------------------------------------------------------------------------
// mrps_dp
// datapath: code memories, residue counters, column code buffer, result reg
// ----------------------------------------------------------------------------
module mrps_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mrps_pkg::t_dp_cmd              i_cmd,
    output mrps_pkg::t_dp_sts              o_sts,
    input  logic [mrps_pkg::SEQ_ROW_W-1:0] i_seq_row,
    input  logic [mrps_pkg::COLUMN_W-1:0]  i_column,
    input  logic                           i_is_residue,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_first_row,
    output logic [2:0]                     o_second_row,
    output logic [mrps_pkg::OUTCOME_W-1:0] o_outcome,
    output logic                           o_last_pair
);

    import mrps_pkg::*;

    logic [CNT_W-1:0]     r_cnt_ref [NUM_SEQS];
    logic [CNT_W-1:0]     r_cnt_alt [NUM_SEQS];
    logic [CODE_W-1:0]    r_rcode   [NUM_SEQS];
    logic [COL_W-1:0]     r_col;
    logic [COL_W-1:0]     r_acol;
    logic                 r_res1;
    logic                 r_kok;
    logic                 r_out_valid;
    logic [ROW_W-1:0]     r_out_r1;
    logic [ROW_W-1:0]     r_out_r2;
    logic [OUTCOME_W-1:0] r_out_outcome;
    logic                 r_out_last;

    logic [ROW_W-1:0]     ld_row;
    logic [CNT_W-1:0]     cnt_sel;
    logic [CNT_W-1:0]     ld_k;
    logic [CNT_W-1:0]     n_cnt;
    logic [CODE_W-1:0]    ld_code;
    logic [ADDR_W-1:0]    ld_addr;
    logic                 arc_we;
    logic [CODE_W-1:0]    ref_rdata;
    logic [CODE_W-1:0]    alt_rdata;
    logic [COL_W-1:0]     arc_rdata;
    logic [CODE_W-1:0]    sel_code;
    logic [CNT_W-1:0]     sel_k;
    logic [COL_W-1:0]     alt_col;
    logic [OUTCOME_W-1:0] n_outcome;

    // cell recoding for loads
    always_comb begin
        ld_row  = ROW_W'(i_seq_row);
        cnt_sel = i_cmd.load_alt ? r_cnt_alt[ld_row] : r_cnt_ref[ld_row];
        ld_k    = (i_column == '0) ? '0 : cnt_sel;
        ld_code = {ld_k, i_is_residue};
        ld_addr = {ld_row, COL_W'(i_column)};
        n_cnt   = (i_is_residue && ld_k != CNT_MAX) ? ld_k + 1'b1 : ld_k;
        arc_we  = i_cmd.load_alt && i_is_residue && (32'(ld_k) < NUM_COLS);
    end

    // residue counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SEQS; i++) begin
                r_cnt_ref[i] <= '0;
                r_cnt_alt[i] <= '0;
            end
        end else begin
            if (i_cmd.load_ref) begin
                r_cnt_ref[ld_row] <= n_cnt;
            end
            if (i_cmd.load_alt) begin
                r_cnt_alt[ld_row] <= n_cnt;
            end
        end
    end

    // code of the selected row of the scored column
    always_comb begin
        sel_code = r_rcode[i_cmd.rsel];
        sel_k    = sel_code[CODE_W-1:1];
        alt_col  = i_cmd.alt_from_ram ? arc_rdata : r_acol;
    end

    // reference codes
    mrps_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DEPTH)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_ref),
        .i_waddr (ld_addr),
        .i_wdata (ld_code),
        .i_re    (i_cmd.fetch_re),
        .i_raddr ({i_cmd.fetch_row, r_col}),
        .o_rdata (ref_rdata)
    );

    // alternative codes
    mrps_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DEPTH)
    ) u_alt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_alt),
        .i_waddr (ld_addr),
        .i_wdata (ld_code),
        .i_re    (i_cmd.alt_re),
        .i_raddr ({i_cmd.row2, alt_col}),
        .o_rdata (alt_rdata)
    );

    // column of each alternative residue
    mrps_ram #(
        .WIDTH (COL_W),
        .DEPTH (DEPTH)
    ) u_arc_ram (
        .i_clk   (i_clk),
        .i_we    (arc_we),
        .i_waddr ({ld_row, ld_k[COL_W-1:0]}),
        .i_wdata (COL_W'(i_column)),
        .i_re    (i_cmd.row_start),
        .i_raddr ({i_cmd.row1, sel_k[COL_W-1:0]}),
        .o_rdata (arc_rdata)
    );

    // scored column buffer and per-row state
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_col) begin
            r_col <= COL_W'(i_column);
        end
        if (i_cmd.store_en) begin
            r_rcode[i_cmd.store_row] <= ref_rdata;
        end
        if (i_cmd.row_start) begin
            r_res1 <= sel_code[0];
            r_kok  <= sel_code[0] && (32'(sel_k) < NUM_COLS);
        end
        if (i_cmd.alt_re && i_cmd.alt_from_ram) begin
            r_acol <= arc_rdata;
        end
    end

    // pair outcome
    always_comb begin
        if (!r_res1 || !sel_code[0]) begin
            n_outcome = OUT_GAP;
        end else if (r_kok && alt_rdata == sel_code) begin
            n_outcome = OUT_HIT;
        end else begin
            n_outcome = OUT_MISS;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // second row is the row whose code is selected; row2 may already
    // address the prefetch of the next pair
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_r1      <= i_cmd.row1;
            r_out_r2      <= i_cmd.rsel;
            r_out_outcome <= n_outcome;
            r_out_last    <= i_cmd.last;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_first_row    = 3'(r_out_r1);
    assign o_second_row   = 3'(r_out_r2);
    assign o_outcome      = r_out_outcome;
    assign o_last_pair    = r_out_last;

endmodule

[hdl/mrps_ctrl.sv]
// ----------------------------------------------------------------------------
// mrps_ctrl
// controller: input acceptance, column fetch and row pair sequencing
// ----------------------------------------------------------------------------
module mrps_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [mrps_pkg::CMD_W-1:0]     i_cmd_code,
    input  logic [mrps_pkg::SEQ_ROW_W-1:0] i_seq_row,
    input  logic [mrps_pkg::COLUMN_W-1:0]  i_column,
    input  mrps_pkg::t_dp_sts              i_sts,
    output mrps_pkg::t_dp_cmd              o_cmd
);

    import mrps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_ROW,
        S_PAIR_START,
        S_PAIR_RUN
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [FCNT_W-1:0] r_fcnt;
    logic [FCNT_W-1:0] n_fcnt;
    logic [ROW_W-1:0]  r_r1;
    logic [ROW_W-1:0]  n_r1;
    logic [ROW_W-1:0]  r_r2;
    logic [ROW_W-1:0]  n_r2;

    logic accept;
    logic col_ok;
    logic row_ok;
    logic r2_end;
    logic r1_end;

    assign accept = i_s_tvalid && (r_state == S_IDLE);
    assign col_ok = 32'(i_column) < NUM_COLS;
    assign row_ok = 32'(i_seq_row) < NUM_SEQS;
    assign r2_end = 32'(r_r2) == NUM_SEQS - 1;
    assign r1_end = 32'(r_r1) == NUM_SEQS - 2;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_fcnt  = r_fcnt;
        n_r1    = r_r1;
        n_r2    = r_r2;
        o_cmd   = '0;
        o_cmd.row1 = r_r1;
        o_cmd.row2 = r_r2;
        o_cmd.rsel = r_r2;
        case (r_state)
            S_IDLE: begin
                if (accept && col_ok) begin
                    case (i_cmd_code)
                        CMD_LOAD_REF: o_cmd.load_ref = row_ok;
                        CMD_LOAD_ALT: o_cmd.load_alt = row_ok;
                        CMD_SCORE: begin
                            o_cmd.cap_col = 1'b1;
                            n_fcnt  = '0;
                            n_state = S_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                // the registered read returns each code in the cycle after its address
                o_cmd.fetch_re  = 32'(r_fcnt) < NUM_SEQS;
                o_cmd.fetch_row = r_fcnt[ROW_W-1:0];
                o_cmd.store_en  = r_fcnt != '0;
                o_cmd.store_row = ROW_W'(r_fcnt - 1'b1);
                n_fcnt = r_fcnt + 1'b1;
                if (32'(r_fcnt) == NUM_SEQS) begin
                    n_r1    = '0;
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.rsel      = r_r1;
                o_cmd.row_start = 1'b1;
                n_r2    = r_r1 + 1'b1;
                n_state = S_PAIR_START;
            end
            S_PAIR_START: begin
                o_cmd.alt_re       = 1'b1;
                o_cmd.alt_from_ram = 1'b1;
                n_state = S_PAIR_RUN;
            end
            S_PAIR_RUN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = r1_end && r2_end;
                    if (r2_end) begin
                        if (r1_end) begin
                            n_state = S_IDLE;
                        end else begin
                            n_r1    = r_r1 + 1'b1;
                            n_state = S_ROW;
                        end
                    end else begin
                        // prefetch the next row two code
                        n_r2         = r_r2 + 1'b1;
                        o_cmd.alt_re = 1'b1;
                        o_cmd.row2   = r_r2 + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fcnt  <= '0;
            r_r1    <= '0;
            r_r2    <= '0;
        end else begin
            r_state <= n_state;
            r_fcnt  <= n_fcnt;
            r_r1    <= n_r1;
            r_r2    <= n_r2;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

[hdl/mrps_checker.sv]
// ----------------------------------------------------------------------------
// mrps_checker
// port level checks of the residue pair scorer, bound to the top level
// ----------------------------------------------------------------------------
`include "msa_residue_pair_scorer_top_defines.svh"

module mrps_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [mrps_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [mrps_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                             o_m_tlast
);

    import mrps_pkg::*;

    logic score_take;
    logic top_pair;

    // accepted score beat for a column in range
    assign score_take = i_s_tvalid && o_s_tready && i_s_tdata[1:0] == CMD_SCORE
                        && 32'(i_s_tdata[14:5]) < NUM_COLS;

    // result beat carries the highest row pair
    assign top_pair = 32'(o_m_tdata[2:0]) == NUM_SEQS - 2
                      && 32'(o_m_tdata[5:3]) == NUM_SEQS - 1;

    // a stalled result stays offered
    `MRPS_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid)

    // an accepted score item blocks the input while the column is worked
    `MRPS_ASSERT_CLK(a_score_busy, i_clk, i_rst_n, score_take |=> !o_s_tready)

    // results only appear while a column is being scored
    `MRPS_ASSERT_CLK(a_rose_busy, i_clk, i_rst_n, $rose(o_m_tvalid) |-> !$past(o_s_tready))

    // the final pair marker sits on the highest row pair
    `MRPS_ASSERT_CLK(a_last_pair, i_clk, i_rst_n, o_m_tvalid && o_m_tlast |-> top_pair)

    // the output is idle out of reset
    `MRPS_ASSERT_ALWAYS(a_reset_idle, i_clk, !$past(i_rst_n) |-> !o_m_tvalid)

endmodule

bind msa_residue_pair_scorer_top mrps_checker u_mrps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

[tb/sv/msa_pair_outcome_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msa_pair_outcome_checker
// watches both stream ports of the residue pair scorer, keeps its own copy
// of the two alignments and matches every pair outcome beat in order
// ----------------------------------------------------------------------------
module msa_pair_outcome_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // cmd[1:0], seq_row[4:2], column[14:5], is_residue[15]
    input  logic [mrps_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // first_row[2:0], second_row[5:3], outcome[7:6]
    input  logic [mrps_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    // last_pair
    input  logic                             i_m_tlast,
    output int                               o_fail_count,
    output int                               o_pending
);
    import mrps_pkg::*;

    localparam int REF_SIDE = 0;
    localparam int ALT_SIDE = 1;

    typedef struct packed {
        logic [ROW_W-1:0]     first_row;
        logic [ROW_W-1:0]     second_row;
        logic [OUTCOME_W-1:0] outcome;
        logic                 last_pair;
    } t_pair_result;

    // column codes of both alignments, residue columns of the alternative
    logic [CODE_W-1:0] cell_codes [2][DEPTH];
    logic [COL_W-1:0]  alt_res_cols [DEPTH];
    logic [CNT_W-1:0]  res_cnt [2][NUM_SEQS];

    t_pair_result pair_outcome_q [$];
    int           fail_cnt = 0;

    // recode one loaded cell into its column code
    task automatic store_cell(input int side, input int row, input int col,
                              input logic residue);
        int idx;
        int k;
        idx = row * NUM_COLS + col;
        if (col == 0) res_cnt[side][row] = '0;
        k = int'(res_cnt[side][row]);
        if (residue) begin
            cell_codes[side][idx] = CODE_W'(2 * k + 1);
            if (side == ALT_SIDE && k < NUM_COLS) begin
                alt_res_cols[row * NUM_COLS + k] = COL_W'(col);
            end
            if (k < int'(CNT_MAX)) res_cnt[side][row] = CNT_W'(k + 1);
        end else begin
            cell_codes[side][idx] = CODE_W'(2 * k);
        end
    endtask

    // one outcome per row pair of a reference column, first row outer
    task automatic score_pairs(input int col);
        logic [CODE_W-1:0]    c1;
        logic [CODE_W-1:0]    c2;
        logic                 k_ok;
        int                   k;
        int                   acol;
        logic [OUTCOME_W-1:0] oc;
        t_pair_result         pr;
        for (int r1 = 0; r1 < NUM_SEQS - 1; r1++) begin
            c1 = cell_codes[REF_SIDE][r1 * NUM_COLS + col];
            k = int'(c1 >> 1);
            // residue index past the columns has no recorded column
            k_ok = c1[0] && (k < NUM_COLS);
            acol = 0;
            if (k_ok) acol = int'(alt_res_cols[r1 * NUM_COLS + k]);
            for (int r2 = r1 + 1; r2 < NUM_SEQS; r2++) begin
                c2 = cell_codes[REF_SIDE][r2 * NUM_COLS + col];
                if (!c1[0] || !c2[0]) begin
                    oc = OUT_GAP;
                end else if (k_ok && cell_codes[ALT_SIDE][r2 * NUM_COLS + acol] == c2) begin
                    oc = OUT_HIT;
                end else begin
                    oc = OUT_MISS;
                end
                pr.first_row  = ROW_W'(r1);
                pr.second_row = ROW_W'(r2);
                pr.outcome    = oc;
                pr.last_pair  = (r1 == NUM_SEQS - 2) && (r2 == NUM_SEQS - 1);
                pair_outcome_q.push_back(pr);
            end
        end
    endtask

    // compare output beats, then predict from input beats
    always @(posedge i_clk) begin : watch
        logic [CMD_W-1:0]     cmd;
        logic [SEQ_ROW_W-1:0] row;
        logic [COLUMN_W-1:0]  col;
        t_pair_result         got;
        t_pair_result         want;
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_SEQS; r++) begin
                res_cnt[REF_SIDE][r] = '0;
                res_cnt[ALT_SIDE][r] = '0;
            end
            pair_outcome_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.first_row  = i_m_tdata[2:0];
                got.second_row = i_m_tdata[5:3];
                got.outcome    = i_m_tdata[7:6];
                got.last_pair  = i_m_tlast;
                if (pair_outcome_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("%0t unexpected beat: pair %0d/%0d outcome %0d last %0b",
                                 $time, got.first_row, got.second_row, got.outcome,
                                 got.last_pair);
                    end
                end else begin
                    want = pair_outcome_q.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $write("%0t mismatch: expected pair %0d/%0d outcome %0d last %0b, ",
                                   $time, want.first_row, want.second_row, want.outcome,
                                   want.last_pair);
                            $display("got pair %0d/%0d outcome %0d last %0b",
                                     got.first_row, got.second_row, got.outcome,
                                     got.last_pair);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                cmd = i_s_tdata[1:0];
                row = i_s_tdata[4:2];
                col = i_s_tdata[14:5];
                case (cmd)
                    CMD_LOAD_REF, CMD_LOAD_ALT: begin
                        if (int'(row) < NUM_SEQS && int'(col) < NUM_COLS) begin
                            store_cell((cmd == CMD_LOAD_ALT) ? ALT_SIDE : REF_SIDE,
                                       int'(row), int'(col), i_s_tdata[15]);
                        end
                    end
                    CMD_SCORE: begin
                        if (int'(col) < NUM_COLS) score_pairs(int'(col));
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= pair_outcome_q.size();
    end

endmodule

[tb/sv/msa_residue_pair_scorer_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msa_residue_pair_scorer_top_tb
// loads small reference and alternative alignments, scores their columns
// under several idle and stall mixes, and takes the verdict from the checker
// ----------------------------------------------------------------------------
module msa_residue_pair_scorer_top_tb;
    import mrps_pkg::*;

    // the one command code the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    int                     fail_count;
    int                     pending;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int set_width      = 1;
    int sent_items     = 0;

    msa_residue_pair_scorer_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    msa_pair_outcome_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls at random
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input int row, input int col,
                             input int residue);
        logic [IN_TDATA_W-1:0] beat;
        beat        = '0;
        beat[1:0]   = cmd;
        beat[4:2]   = row[2:0];
        beat[14:5]  = col[9:0];
        beat[15]    = residue[0];
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (cmd != CMD_UNUSED) sent_items++;
    endtask

    // both alignments over the first columns; the alternative keeps each
    // row's residue count so every score reads only written cells
    task automatic load_set(input int width);
        logic [15:0] ref_pat [NUM_SEQS];
        logic [15:0] alt_pat [NUM_SEQS];
        int          n;
        int          pos;
        logic        row_major;
        for (int r = 0; r < NUM_SEQS; r++) begin
            ref_pat[r] = '0;
            for (int c = 0; c < width; c++) ref_pat[r][c] = ($urandom_range(0, 99) < 70);
            if ($urandom_range(0, 99) < 60) begin
                alt_pat[r] = ref_pat[r];
            end else begin
                // same residues, gaps moved around
                alt_pat[r] = '0;
                n = $countones(ref_pat[r]);
                while (n > 0) begin
                    pos = $urandom_range(0, width - 1);
                    if (!alt_pat[r][pos]) begin
                        alt_pat[r][pos] = 1'b1;
                        n--;
                    end
                end
            end
        end
        row_major = $urandom_range(0, 1);
        for (int a = 0; a < 2; a++) begin
            for (int i = 0; i < NUM_SEQS * width; i++) begin
                if (row_major) begin
                    send_beat(a ? CMD_LOAD_ALT : CMD_LOAD_REF, i / width, i % width,
                              a ? alt_pat[i / width][i % width] : ref_pat[i / width][i % width]);
                end else begin
                    send_beat(a ? CMD_LOAD_ALT : CMD_LOAD_REF, i % NUM_SEQS, i / NUM_SEQS,
                              a ? alt_pat[i % NUM_SEQS][i / NUM_SEQS]
                                : ref_pat[i % NUM_SEQS][i / NUM_SEQS]);
                end
            end
        end
        set_width = width;
    endtask

    // sets of loads followed by scores, with stray beats mixed in
    task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
        int start;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        start          = sent_items;
        while (sent_items - start < quota) begin
            load_set(($urandom_range(0, 99) < 90) ? $urandom_range(1, 2) : 3);
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 99) < 25) begin
                    case ($urandom_range(0, 2))
                        0: send_beat(CMD_UNUSED, $urandom_range(0, 7),
                                     $urandom_range(0, NUM_COLS - 1), $urandom_range(0, 1));
                        // out of order reference gap
                        1: send_beat(CMD_LOAD_REF, $urandom_range(0, 7),
                                     $urandom_range(0, NUM_COLS - 1), 0);
                        // out of order alternative cell inside the set
                        default: send_beat(CMD_LOAD_ALT, $urandom_range(0, 7),
                                           $urandom_range(0, set_width - 1),
                                           $urandom_range(0, 1));
                    endcase
                end
                send_beat(CMD_SCORE, $urandom_range(0, 7), $urandom_range(0, set_width - 1),
                          $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        logic [NUM_SEQS-1:0] first_col;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        rst_n    <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-column alignments: hits and gaps, then a miss after a cleared row
        first_col = 8'b1001_0111;
        set_width = 1;
        for (int r = 0; r < NUM_SEQS; r++) send_beat(CMD_LOAD_REF, r, 0, first_col[r]);
        for (int r = 0; r < NUM_SEQS; r++) send_beat(CMD_LOAD_ALT, r, 0, first_col[r]);
        send_beat(CMD_SCORE, 7, 0, 1);
        send_beat(CMD_LOAD_ALT, 2, 0, 0);
        send_beat(CMD_SCORE, 0, 0, 0);
        send_beat(CMD_UNUSED, 7, NUM_COLS - 1, 1);
        send_beat(CMD_LOAD_REF, 4, 0, 0);
        send_beat(CMD_SCORE, 5, 0, 1);

        run_phase(0, 0, 20);
        run_phase(61, 0, 20);
        run_phase(0, 61, 20);
        run_phase(38, 38, 20);
        s_tvalid <= 1'b0;

        // drain, then watch for stray beats
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        sink_stall_pct = 0;
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/mrps_pkg.sv
hdl/mrps_ram.sv
hdl/mrps_dp.sv
hdl/mrps_ctrl.sv
hdl/msa_residue_pair_scorer_top.sv
hdl/mrps_checker.sv
tb/sv/msa_pair_outcome_checker.sv
tb/sv/msa_residue_pair_scorer_top_tb.sv
